>>> hw/rtl/linked_process_queue_table_unit_macros.svh
// Assertion macros for the checker file.
`ifndef LINKED_PROCESS_QUEUE_TABLE_UNIT_MACROS_SVH
`define LINKED_PROCESS_QUEUE_TABLE_UNIT_MACROS_SVH
// Assert that a property holds on every edge outside reset.
`define LPQT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Assert a property that must also hold while reset is applied.
`define LPQT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> hw/rtl/lpqt_pkg.sv
// Shared types and constants for the linked process queue table.
package lpqt_pkg;
  localparam int NumProcs   = 64;
  localparam int NumQueues  = 16;
  localparam int NumEntries = NumProcs + 2 * NumQueues;
  localparam int IdxW       = $clog2(NumEntries);
  localparam int QcW        = $clog2(NumQueues + 1);
  localparam int StepW      = $clog2(NumProcs + 1);
  localparam int KeyW       = 32;

  localparam logic [1:0] KindNew    = 2'd0;
  localparam logic [1:0] KindAppend = 2'd1;
  localparam logic [1:0] KindPop    = 2'd2;
  localparam logic [1:0] KindInsert = 2'd3;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusEmpty = 2'd1;
  localparam logic [1:0] StatusFull  = 2'd2;

  typedef enum logic [3:0] {
    StIdle, StDecode, StNewW, StPopRd1, StPopChk, StPopRd2, StPopW,
    StAppRd, StAppW1, StAppW2, StInsRd, StInsChk, StInsKey, StInsW1, StInsW2,
    StDone
  } state_t;

  // Memory selector for a datapath command.
  typedef enum logic [1:0] {
    MemNext, MemPrev, MemKey
  } mem_sel_t;

  // Address source for a datapath command.
  typedef enum logic [2:0] {
    AddrHead, AddrTail, AddrProc, AddrCurr, AddrNxt, AddrRd
  } addr_sel_t;

  // Data source for a link write.
  typedef enum logic [2:0] {
    DataHead, DataTail, DataProc, DataCurr, DataNxt, DataRd
  } data_sel_t;

  typedef struct packed {
    logic       load;
    logic       rd_en;
    addr_sel_t  rd_addr;
    mem_sel_t   rd_mem;
    logic       wr_next;
    addr_sel_t  wr_next_addr;
    data_sel_t  wr_next_data;
    logic       wr_prev;
    addr_sel_t  wr_prev_addr;
    data_sel_t  wr_prev_data;
    logic       wr_key;
    logic       set_nxt;
    logic       adv;
    logic       bump_q;
    logic       res_load;
    logic [1:0] res_status;
    logic       res_ok;
    logic       res_q;
    logic       res_rd;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       q_bad;
    logic       full;
    logic       proc_bad;
    logic       rd_is_tail;
    logic       rd_not_proc;
    logic       key_stop;
    logic       steps_out;
  } stat_t;
endpackage

>>> hw/rtl/lpqt_ram.sv
// Generic single write, single read RAM with registered read.
module lpqt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write and read registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/lpqt_ctrl.sv
// Controller state machine for the queue table.
module lpqt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  lpqt_pkg::stat_t st,
  output lpqt_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done
);
  lpqt_pkg::state_t state, state_next;

  // Advance the state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpqt_pkg::StIdle;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      lpqt_pkg::StIdle: if (start) state_next = lpqt_pkg::StDecode;
      lpqt_pkg::StDecode: begin
        priority if (st.kind == lpqt_pkg::KindNew) begin
          state_next = st.full ? lpqt_pkg::StDone : lpqt_pkg::StNewW;
        end else if (st.q_bad) begin
          state_next = lpqt_pkg::StDone;
        end else if (st.kind == lpqt_pkg::KindPop) begin
          state_next = lpqt_pkg::StPopRd1;
        end else if (st.proc_bad) begin
          state_next = lpqt_pkg::StDone;
        end else if (st.kind == lpqt_pkg::KindAppend) begin
          state_next = lpqt_pkg::StAppRd;
        end else begin
          state_next = lpqt_pkg::StInsRd;
        end
      end
      lpqt_pkg::StNewW:   state_next = lpqt_pkg::StDone;
      lpqt_pkg::StPopRd1: state_next = lpqt_pkg::StPopChk;
      lpqt_pkg::StPopChk:
        state_next = (st.rd_is_tail || st.rd_not_proc) ? lpqt_pkg::StDone
                                                       : lpqt_pkg::StPopRd2;
      lpqt_pkg::StPopRd2: state_next = lpqt_pkg::StPopW;
      lpqt_pkg::StPopW:   state_next = lpqt_pkg::StDone;
      lpqt_pkg::StAppRd:  state_next = lpqt_pkg::StAppW1;
      lpqt_pkg::StAppW1:  state_next = lpqt_pkg::StAppW2;
      lpqt_pkg::StAppW2:  state_next = lpqt_pkg::StDone;
      lpqt_pkg::StInsRd:  state_next = lpqt_pkg::StInsChk;
      lpqt_pkg::StInsChk:
        state_next = (st.rd_is_tail || st.steps_out) ? lpqt_pkg::StInsW1
                                                     : lpqt_pkg::StInsKey;
      lpqt_pkg::StInsKey:
        state_next = st.key_stop ? lpqt_pkg::StInsW1 : lpqt_pkg::StInsRd;
      lpqt_pkg::StInsW1:  state_next = lpqt_pkg::StInsW2;
      lpqt_pkg::StInsW2:  state_next = lpqt_pkg::StDone;
      lpqt_pkg::StDone:   state_next = lpqt_pkg::StIdle;
      default:            state_next = lpqt_pkg::StIdle;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    cmd.rd_addr = lpqt_pkg::AddrHead;
    cmd.rd_mem = lpqt_pkg::MemNext;
    cmd.wr_next_addr = lpqt_pkg::AddrHead;
    cmd.wr_next_data = lpqt_pkg::DataTail;
    cmd.wr_prev_addr = lpqt_pkg::AddrTail;
    cmd.wr_prev_data = lpqt_pkg::DataHead;
    busy = (state != lpqt_pkg::StIdle);
    done = (state == lpqt_pkg::StDone);
    cmd.load = (state == lpqt_pkg::StIdle) && start;
    unique case (state)
      lpqt_pkg::StDecode: begin
        cmd.res_load = 1'b1;
        cmd.res_status = (st.kind == lpqt_pkg::KindNew && st.full) ?
                         lpqt_pkg::StatusFull : lpqt_pkg::StatusEmpty;
      end
      lpqt_pkg::StNewW: begin
        cmd.wr_next = 1'b1;
        cmd.wr_prev = 1'b1;
        cmd.bump_q = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_q = 1'b1;
        cmd.res_status = lpqt_pkg::StatusOk;
      end
      lpqt_pkg::StPopRd1: begin
        cmd.rd_en = 1'b1;
      end
      lpqt_pkg::StPopChk: begin
        // Hold first entry, then read its successor.
        cmd.set_nxt = 1'b1;
        cmd.rd_en = 1'b1;
        cmd.rd_addr = lpqt_pkg::AddrRd;
      end
      lpqt_pkg::StPopRd2: begin
        // Keep the successor of the first entry on the read port.
        cmd.rd_en = 1'b1;
        cmd.rd_addr = lpqt_pkg::AddrNxt;
      end
      lpqt_pkg::StPopW: begin
        cmd.wr_next = 1'b1;
        cmd.wr_next_addr = lpqt_pkg::AddrHead;
        cmd.wr_next_data = lpqt_pkg::DataRd;
        cmd.wr_prev = 1'b1;
        cmd.wr_prev_addr = lpqt_pkg::AddrRd;
        cmd.wr_prev_data = lpqt_pkg::DataHead;
        cmd.res_load = 1'b1;
        cmd.res_ok = 1'b1;
        cmd.res_status = lpqt_pkg::StatusOk;
      end
      lpqt_pkg::StAppRd: begin
        cmd.rd_en = 1'b1;
        cmd.rd_addr = lpqt_pkg::AddrTail;
        cmd.rd_mem = lpqt_pkg::MemPrev;
      end
      lpqt_pkg::StAppW1: begin
        cmd.set_nxt = 1'b1;
        cmd.wr_next = 1'b1;
        cmd.wr_next_addr = lpqt_pkg::AddrRd;
        cmd.wr_next_data = lpqt_pkg::DataProc;
        cmd.wr_prev = 1'b1;
        cmd.wr_prev_addr = lpqt_pkg::AddrProc;
        cmd.wr_prev_data = lpqt_pkg::DataRd;
      end
      lpqt_pkg::StAppW2: begin
        cmd.wr_next = 1'b1;
        cmd.wr_next_addr = lpqt_pkg::AddrProc;
        cmd.wr_next_data = lpqt_pkg::DataTail;
        cmd.wr_prev = 1'b1;
        cmd.wr_prev_addr = lpqt_pkg::AddrTail;
        cmd.wr_prev_data = lpqt_pkg::DataProc;
        cmd.res_load = 1'b1;
        cmd.res_ok = 1'b1;
        cmd.res_status = lpqt_pkg::StatusOk;
      end
      lpqt_pkg::StInsRd: begin
        cmd.rd_en = 1'b1;
        cmd.rd_addr = lpqt_pkg::AddrCurr;
      end
      lpqt_pkg::StInsChk: begin
        // Hold the successor and fetch its key.
        cmd.set_nxt = 1'b1;
        cmd.rd_en = 1'b1;
        cmd.rd_addr = lpqt_pkg::AddrRd;
        cmd.rd_mem = lpqt_pkg::MemKey;
      end
      lpqt_pkg::StInsKey: begin
        cmd.adv = !st.key_stop;
      end
      lpqt_pkg::StInsW1: begin
        cmd.wr_key = 1'b1;
        cmd.wr_next = 1'b1;
        cmd.wr_next_addr = lpqt_pkg::AddrCurr;
        cmd.wr_next_data = lpqt_pkg::DataProc;
        cmd.wr_prev = 1'b1;
        cmd.wr_prev_addr = lpqt_pkg::AddrProc;
        cmd.wr_prev_data = lpqt_pkg::DataCurr;
      end
      lpqt_pkg::StInsW2: begin
        cmd.wr_next = 1'b1;
        cmd.wr_next_addr = lpqt_pkg::AddrProc;
        cmd.wr_next_data = lpqt_pkg::DataNxt;
        cmd.wr_prev = 1'b1;
        cmd.wr_prev_addr = lpqt_pkg::AddrNxt;
        cmd.wr_prev_data = lpqt_pkg::DataProc;
        cmd.res_load = 1'b1;
        cmd.res_ok = 1'b1;
        cmd.res_status = lpqt_pkg::StatusOk;
      end
      default: begin
      end
    endcase
  end
endmodule

>>> hw/rtl/lpqt_dp.sv
// Datapath: link and key memories, walk registers and result register.
module lpqt_dp (
  input  logic            clk,
  input  logic            rst,
  input  lpqt_pkg::cmd_t  cmd,
  input  logic [1:0]      kind,
  input  logic [3:0]      queue_handle,
  input  logic [5:0]      process_id,
  input  logic [31:0]     priority_key,
  output lpqt_pkg::stat_t st,
  output logic [5:0]      result_id,
  output logic [1:0]      status
);
  localparam int IdxW = lpqt_pkg::IdxW;

  logic [1:0]                  kind_r;
  logic [3:0]                  q_r;
  logic [5:0]                  proc_r;
  logic [31:0]                 key_r;
  logic [IdxW-1:0]             curr, nxt;
  logic [lpqt_pkg::StepW-1:0]  steps;
  logic [lpqt_pkg::QcW-1:0]    queues_created;
  lpqt_pkg::mem_sel_t          rd_mem_r;
  logic [IdxW-1:0]             head_idx, tail_idx, proc_idx;
  logic [IdxW-1:0]             next_rd, prev_rd, rd_link;
  logic [31:0]                 key_rd;
  logic [IdxW-1:0]             raddr, wn_addr, wp_addr, wn_data, wp_data;
  logic [lpqt_pkg::QcW-1:0]    hq;

  // Clamp a table index to the entry range.
  function automatic logic [IdxW-1:0] clamp(input logic [IdxW-1:0] i);
    clamp = (32'(i) < lpqt_pkg::NumEntries) ? i : '0;
  endfunction

  function automatic logic [IdxW-1:0] pick_addr(
    input lpqt_pkg::addr_sel_t s, input logic [IdxW-1:0] h, t, p, c, n, r);
    unique case (s)
      lpqt_pkg::AddrHead: pick_addr = h;
      lpqt_pkg::AddrTail: pick_addr = t;
      lpqt_pkg::AddrProc: pick_addr = p;
      lpqt_pkg::AddrCurr: pick_addr = c;
      lpqt_pkg::AddrNxt:  pick_addr = n;
      default:            pick_addr = r;
    endcase
  endfunction

  function automatic logic [IdxW-1:0] pick_data(
    input lpqt_pkg::data_sel_t s, input logic [IdxW-1:0] h, t, p, c, n, r);
    unique case (s)
      lpqt_pkg::DataHead: pick_data = h;
      lpqt_pkg::DataTail: pick_data = t;
      lpqt_pkg::DataProc: pick_data = p;
      lpqt_pkg::DataCurr: pick_data = c;
      lpqt_pkg::DataNxt:  pick_data = n;
      default:            pick_data = r;
    endcase
  endfunction

  // Sentinel indexes: a new queue uses the creation count.
  assign hq = (kind_r == lpqt_pkg::KindNew) ? queues_created
                                            : lpqt_pkg::QcW'(q_r);
  assign head_idx = IdxW'(lpqt_pkg::NumProcs) + IdxW'({hq, 1'b0});
  assign tail_idx = head_idx + IdxW'(1);
  assign proc_idx = IdxW'(proc_r);

  assign rd_link = clamp((rd_mem_r == lpqt_pkg::MemPrev) ? prev_rd : next_rd);

  assign raddr   = pick_addr(cmd.rd_addr, head_idx, tail_idx, proc_idx, curr, nxt,
                             rd_link);
  assign wn_addr = pick_addr(cmd.wr_next_addr, head_idx, tail_idx, proc_idx, curr,
                             nxt, rd_link);
  assign wp_addr = pick_addr(cmd.wr_prev_addr, head_idx, tail_idx, proc_idx, curr,
                             nxt, rd_link);
  assign wn_data = pick_data(cmd.wr_next_data, head_idx, tail_idx, proc_idx, curr,
                             nxt, rd_link);
  assign wp_data = pick_data(cmd.wr_prev_data, head_idx, tail_idx, proc_idx, curr,
                             nxt, rd_link);

  lpqt_ram #(.Width(IdxW), .Depth(lpqt_pkg::NumEntries)) u_next (
    .clk(clk), .we(cmd.wr_next), .waddr(wn_addr), .wdata(wn_data),
    .raddr(raddr), .rdata(next_rd));
  lpqt_ram #(.Width(IdxW), .Depth(lpqt_pkg::NumEntries)) u_prev (
    .clk(clk), .we(cmd.wr_prev), .waddr(wp_addr), .wdata(wp_data),
    .raddr(raddr), .rdata(prev_rd));
  lpqt_ram #(.Width(32), .Depth(lpqt_pkg::NumEntries)) u_key (
    .clk(clk), .we(cmd.wr_key), .waddr(proc_idx), .wdata(key_r),
    .raddr(raddr), .rdata(key_rd));

  // Status to the controller.
  always_comb begin
    st.kind        = kind_r;
    st.q_bad       = lpqt_pkg::QcW'(q_r) >= queues_created;
    st.full        = 32'(queues_created) >= lpqt_pkg::NumQueues;
    st.proc_bad    = 32'(proc_r) >= lpqt_pkg::NumProcs;
    st.rd_is_tail  = rd_link == tail_idx;
    st.rd_not_proc = 32'(rd_link) >= lpqt_pkg::NumProcs;
    st.key_stop    = !(key_r <= key_rd);
    st.steps_out   = 32'(steps) >= lpqt_pkg::NumProcs;
  end

  // Capture the request and walk the list.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      q_r    <= queue_handle;
      proc_r <= process_id;
      key_r  <= priority_key;
      curr   <= IdxW'(lpqt_pkg::NumProcs) + IdxW'({queue_handle, 1'b0});
      steps  <= '0;
    end else if (cmd.adv) begin
      curr  <= nxt;
      steps <= steps + 1'b1;
    end
    if (cmd.rd_en) begin
      rd_mem_r <= cmd.rd_mem;
    end
    if (cmd.set_nxt) begin
      nxt <= rd_link;
    end
  end

  // Hold the queue count.
  always_ff @(posedge clk) begin
    if (rst) begin
      queues_created <= '0;
    end else if (cmd.bump_q) begin
      queues_created <= queues_created + 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status <= cmd.res_status;
      priority if (cmd.res_q) begin
        result_id <= 6'(queues_created);
      end else if (cmd.res_ok) begin
        result_id <= (kind_r == lpqt_pkg::KindPop) ? 6'(nxt) : proc_r;
      end else begin
        result_id <= '0;
      end
    end
  end
endmodule

>>> hw/rtl/linked_process_queue_table_unit.sv
// Top level of the linked process queue table.
// Usage: raise start with kind, queue_handle, process_id and priority_key for
// one cycle while busy is low; the request is taken at that edge and busy
// rises until the result has gone out. The result appears on result_id and
// status for exactly one cycle with done high; the receiver cannot stall it.
// Busy stays high through the done cycle; insert by key takes longer for each
// entry passed, and its walk passes at most 64 entries. The next request may
// be taken the cycle after done.
// The walk is set by one registered read of the link memory and one of the
// key memory per entry passed.
// Reset clears the controller and the count of created queues; link and key
// memories are not cleared and are valid only where written.
module linked_process_queue_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  kind,
  input  logic [3:0]  queue_handle,
  input  logic [5:0]  process_id,
  input  logic [31:0] priority_key,
  output logic        busy,
  output logic        done,
  output logic [5:0]  result_id,
  output logic [1:0]  status
);
  lpqt_pkg::cmd_t  cmd;
  lpqt_pkg::stat_t st;

  lpqt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .st(st), .cmd(cmd),
    .busy(busy), .done(done));

  lpqt_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .kind(kind), .queue_handle(queue_handle),
    .process_id(process_id), .priority_key(priority_key), .st(st),
    .result_id(result_id), .status(status));
endmodule

>>> hw/rtl/lpqt_checker.sv
// Port-level checker for the queue table, bound to the top level.
`include "linked_process_queue_table_unit_macros.svh"
module lpqt_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [5:0] result_id,
  input logic [1:0] status
);
  `LPQT_ASSERT(a_done_busy, done |-> busy, "done outside busy")
  `LPQT_ASSERT(a_done_ends, done |=> !busy, "busy after done")
  `LPQT_ASSERT(a_take_busy, (start && !busy) |=> busy && !done, "request not taken")
  `LPQT_ASSERT(a_err_zero, (done && status != lpqt_pkg::StatusOk) |-> result_id == 6'd0,
               "error id")
  `LPQT_ASSERT_ALWAYS(a_rst_idle, rst |=> !busy, "busy after reset")
endmodule

bind linked_process_queue_table_unit lpqt_checker u_lpqt_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .result_id(result_id), .status(status));
